// File: sv/firpad_pkg.sv
// Shared types and constants of the block FIR filter with edge padding.
package firpad_pkg;

    // Field widths of the stream payloads
    localparam int CIDX_W     = 5;
    localparam int VALUE_W    = 16;
    localparam int IN_DATA_W  = 24;
    localparam int FILT_W     = 24;
    localparam int STAT_W     = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_OVERHEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 2'd2;
    localparam logic [CFG_DATA_W-1:0] TAPS_RESET       = 6'd32;

    // Request kinds on the input stream
    localparam logic CMD_COEFF  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_FILTERED = 2'd0;
    localparam logic [STAT_W-1:0] ST_PASS     = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // Saturation bounds of the filtered output
    localparam int SAT_HI = 8388607;
    localparam int SAT_LO = -8388608;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;       // input request accepted this cycle
        logic issue;      // start one multiply-accumulate step
        logic first;      // step opens a new sum
        logic last;       // step closes the sum
        logic pass;       // short mirrored block: forward samples
        logic load_out;   // move the finished result to the output register
        logic final_out;  // that result closes the block
        logic clear_blk;  // drop the collected block
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic done;           // sum (or forwarded sample) is ready
        logic out_free;       // output register can take a result
        logic edge_mode;
        logic keep_overhead;
    } t_dp_stat;

endpackage

// File: sv/fir_block_filter_edge_pad.sv
// Top level of the block FIR filter with zero or mirror edge padding.
// Coefficient and sample requests arrive on the slave stream, one per cycle
// while collecting; the sample with tlast closes the block and input is held
// off until the block's last result has been handed to the output register.
// Each result is one run of the shared multiply-accumulate unit over the
// taps in use (a short mirrored block forwards its samples instead), and
// each block starts with a setup state. The output register lets the next
// result compute while the previous one waits.
module fir_block_filter_edge_pad #(
    parameter int MAX_TAPS        = 32,
    parameter int MAX_BLOCK       = 32,
    parameter int COEFF_FRAC_BITS = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [firpad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [firpad_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // slave stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [firpad_pkg::IN_DATA_W-1:0]      i_s_tdata,  // coeff_index, value, zero pad
    input  logic                                  i_s_tlast,  // last
    input  logic                                  i_s_tuser,  // cmd
    // master stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [firpad_pkg::FILT_W-1:0]         o_m_tdata,  // filtered
    output logic                                  o_m_tlast,  // final_out
    output logic [firpad_pkg::STAT_W-1:0]         o_m_tuser   // status
);
    import firpad_pkg::*;

    localparam int NW  = $clog2(MAX_TAPS + 1);
    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int PW  = $clog2(2 * MAX_TAPS + MAX_BLOCK + 1);
    localparam int TAW = $clog2(MAX_TAPS);

    t_dp_cmd               cmd;
    t_dp_stat              stat;
    logic [NW-1:0]         taps;
    logic [CW-1:0]         len;
    logic [PW-1:0]         pos;
    logic [TAW-1:0]        tap;
    logic [CIDX_W-1:0]     coeff_index;
    logic signed [VALUE_W-1:0] value;

    // Unpack the request payload
    assign coeff_index = i_s_tdata[CIDX_W-1:0];
    assign value       = $signed(i_s_tdata[CIDX_W+VALUE_W-1:CIDX_W]);

    firpad_ctrl #(
        .MAX_TAPS  (MAX_TAPS),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .i_taps     (taps),
        .i_len      (len),
        .o_cmd      (cmd),
        .o_pos      (pos),
        .o_tap      (tap)
    );

    firpad_dp #(
        .MAX_TAPS        (MAX_TAPS),
        .MAX_BLOCK       (MAX_BLOCK),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_s_tuser),
        .i_coeff_index (coeff_index),
        .i_value       (value),
        .i_cmd         (cmd),
        .i_pos         (pos),
        .i_tap         (tap),
        .i_m_tready    (i_m_tready),
        .o_stat        (stat),
        .o_taps        (taps),
        .o_len         (len),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_filtered  (o_m_tdata),
        .o_m_final     (o_m_tlast),
        .o_m_status    (o_m_tuser)
    );

endmodule

// File: sv/firpad_dp.sv
// Datapath: configuration, tap and sample memories, shared MAC, output register.
module firpad_dp #(
    parameter int MAX_TAPS        = 32,
    parameter int MAX_BLOCK       = 32,
    parameter int COEFF_FRAC_BITS = 15,
    localparam int NW  = $clog2(MAX_TAPS + 1),
    localparam int CW  = $clog2(MAX_BLOCK + 1),
    localparam int PW  = $clog2(2 * MAX_TAPS + MAX_BLOCK + 1),
    localparam int TAW = $clog2(MAX_TAPS)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [firpad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [firpad_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_kind,
    input  logic [firpad_pkg::CIDX_W-1:0]         i_coeff_index,
    input  logic signed [firpad_pkg::VALUE_W-1:0] i_value,
    input  firpad_pkg::t_dp_cmd                   i_cmd,
    input  logic [PW-1:0]                         i_pos,
    input  logic [TAW-1:0]                        i_tap,
    input  logic                                  i_m_tready,
    output firpad_pkg::t_dp_stat                  o_stat,
    output logic [NW-1:0]                         o_taps,
    output logic [CW-1:0]                         o_len,
    output logic                                  o_m_tvalid,
    output logic [firpad_pkg::FILT_W-1:0]         o_m_filtered,
    output logic                                  o_m_final,
    output logic [firpad_pkg::STAT_W-1:0]         o_m_status
);
    import firpad_pkg::*;

    localparam int SAW   = $clog2(MAX_BLOCK);
    localparam int ACC_W = 32 + $clog2(MAX_TAPS);
    localparam int IXW   = (TAW > CIDX_W) ? TAW : CIDX_W;
    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] SAT_HI_X = (ACC_W + 1)'(SAT_HI);
    localparam logic signed [ACC_W:0] SAT_LO_X = (ACC_W + 1)'(SAT_LO);

    // Configuration and block state
    logic                  r_edge, r_keep;
    logic [CFG_DATA_W-1:0] r_taps_cfg;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_ovf, n_ovf;

    // Memories
    logic signed [VALUE_W-1:0] tap_mem  [MAX_TAPS];
    logic signed [VALUE_W-1:0] samp_mem [MAX_BLOCK];

    // Pipeline
    logic                      r_s1_v, r_s1_first, r_s1_last, r_s1_pass, r_s1_zero;
    logic signed [VALUE_W-1:0] r_samp_rd, r_tap_rd;
    logic                      r_s2_v, r_s2_first, r_s2_last;
    logic signed [31:0]        r_prod;
    logic signed [VALUE_W-1:0] r_pass_val;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;

    // Output register
    logic                      r_out_v;
    logic [FILT_W-1:0]         r_out_data;
    logic                      r_out_final;
    logic [STAT_W-1:0]         r_out_stat;

    logic [NW-1:0]             taps;
    logic [IXW-1:0]            cidx;
    logic                      coeff_ok;
    logic                      is_sample;
    logic [PW-1:0]             pw_n, pw_l, rel, over, mirr, s0_addr;
    logic                      s0_zero;
    logic signed [ACC_W:0]     rnd, shifted;
    logic [FILT_W-1:0]         sat_val, res_val;
    logic [STAT_W-1:0]         res_stat;

    // Clamp the tap count into 1..MAX_TAPS
    always_comb begin
        if (r_taps_cfg == '0) begin
            taps = NW'(1);
        end else if (32'(r_taps_cfg) > MAX_TAPS) begin
            taps = NW'(MAX_TAPS);
        end else begin
            taps = NW'(r_taps_cfg);
        end
    end

    assign o_taps = taps;
    assign o_len  = r_count;
    assign o_stat = '{done: r_done, out_free: (!r_out_v || i_m_tready),
                      edge_mode: r_edge, keep_overhead: r_keep};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge     <= 1'b0;
            r_keep     <= 1'b0;
            r_taps_cfg <= TAPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EDGE_MODE:     r_edge     <= i_cfg_data[0];
                CFG_KEEP_OVERHEAD: r_keep     <= i_cfg_data[0];
                CFG_TAP_COUNT:     r_taps_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Collect taps and samples
    assign cidx      = IXW'(i_coeff_index);
    assign coeff_ok  = (32'(i_coeff_index) < MAX_TAPS);
    assign is_sample = (i_kind == CMD_SAMPLE);

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_cmd.clear_blk) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end else if (i_cmd.take && is_sample) begin
            if (32'(r_count) < MAX_BLOCK) begin
                n_count = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !is_sample && coeff_ok) begin
            tap_mem[cidx[TAW-1:0]] <= i_value;
        end
        if (i_cmd.take && is_sample && (32'(r_count) < MAX_BLOCK)) begin
            samp_mem[r_count[SAW-1:0]] <= i_value;
        end
    end

    // Map an extended-sequence position onto a stored sample or a zero
    assign pw_n = PW'(taps);
    assign pw_l = PW'(r_count);
    assign rel  = i_pos - pw_n;
    assign over = rel - pw_l;
    assign mirr = pw_n - PW'(1) - i_pos;

    always_comb begin
        s0_addr = i_pos;
        s0_zero = 1'b0;
        if (i_cmd.pass) begin
            s0_addr = i_pos;
        end else if (i_pos < pw_n) begin
            s0_addr = mirr;
            s0_zero = !(r_edge && (mirr < pw_l));
        end else if (rel < pw_l) begin
            s0_addr = rel;
        end else begin
            s0_addr = pw_l - PW'(1) - over;
            s0_zero = !(r_edge && (over < pw_l));
        end
    end

    // Stage 1: registered memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_samp_rd <= samp_mem[s0_addr[SAW-1:0]];
            r_tap_rd  <= tap_mem[i_tap];
        end
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s1_pass  <= i_cmd.pass;
        r_s1_zero  <= s0_zero;
    end

    // Stage 2: product; hold a forwarded sample
    always_ff @(posedge i_clk) begin
        r_prod     <= r_s1_zero ? 32'sd0 : r_samp_rd * r_tap_rd;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s1_v && r_s1_pass) begin
            r_pass_val <= r_samp_rd;
        end
    end

    // Stage 3: accumulate
    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_acc <= r_s2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
            r_done <= r_s2_v && r_s2_last;
        end
    end

    // Round half up, then saturate to the output width
    assign rnd     = $signed({r_acc[ACC_W-1], r_acc}) + RND_HALF;
    assign shifted = rnd >>> COEFF_FRAC_BITS;

    always_comb begin
        if (shifted > SAT_HI_X) begin
            sat_val = FILT_W'(SAT_HI);
        end else if (shifted < SAT_LO_X) begin
            sat_val = FILT_W'(SAT_LO);
        end else begin
            sat_val = shifted[FILT_W-1:0];
        end
    end

    assign res_val  = i_cmd.pass ? FILT_W'(r_pass_val) : sat_val;
    assign res_stat = r_ovf ? ST_OVERFLOW : (i_cmd.pass ? ST_PASS : ST_FILTERED);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data  <= res_val;
            r_out_final <= i_cmd.final_out;
            r_out_stat  <= res_stat;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_filtered = r_out_data;
    assign o_m_final    = r_out_final;
    assign o_m_status   = r_out_stat;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_out && r_out_v && !i_m_tready))
        else $error("result loaded over a stalled result");

    // The block fill never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_BLOCK)
        else $error("sample count beyond store depth");

    // No request is taken while the MAC pipeline is fed
    a_take_vs_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.take && i_cmd.issue))
        else $error("request taken during computation");

endmodule

// File: sv/firpad_ctrl.sv
// Controller: sequences collection, per-output MAC runs and result hand-off.
module firpad_ctrl #(
    parameter int MAX_TAPS  = 32,
    parameter int MAX_BLOCK = 32,
    localparam int NW  = $clog2(MAX_TAPS + 1),
    localparam int CW  = $clog2(MAX_BLOCK + 1),
    localparam int PW  = $clog2(2 * MAX_TAPS + MAX_BLOCK + 1),
    localparam int TAW = $clog2(MAX_TAPS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tlast,
    input  logic                 i_s_tuser,
    output logic                 o_s_tready,
    input  firpad_pkg::t_dp_stat i_stat,
    input  logic [NW-1:0]        i_taps,
    input  logic [CW-1:0]        i_len,
    output firpad_pkg::t_dp_cmd  o_cmd,
    output logic [PW-1:0]        o_pos,
    output logic [TAW-1:0]       o_tap
);
    import firpad_pkg::*;

    localparam int RW = $clog2(MAX_TAPS + MAX_BLOCK + 1);

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_SETUP   = 3'd1;
    localparam logic [2:0] S_ISSUE   = 3'd2;
    localparam logic [2:0] S_WAIT    = 3'd3;
    localparam logic [2:0] S_PUT     = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [NW-1:0] r_k, n_k;
    logic [PW-1:0] r_pos, n_pos;
    logic [RW-1:0] r_cnt, n_cnt;
    logic          r_pass, n_pass;
    logic          take, pass_c, step_last;

    assign o_s_tready = (r_state == S_COLLECT);
    assign take       = i_s_tvalid && o_s_tready;
    assign pass_c     = i_stat.edge_mode && (PW'(i_len) < PW'(i_taps));
    assign step_last  = r_pass || (r_k == i_taps - NW'(1));
    assign o_pos      = r_pos + PW'(r_k);
    assign o_tap      = r_k[TAW-1:0];

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_cmd.take = take;
        o_cmd.pass = r_pass;
        unique case (r_state)
            S_COLLECT: begin
                if (take && (i_s_tuser == CMD_SAMPLE) && i_s_tlast) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_pass = pass_c;
                n_k    = '0;
                if (pass_c) begin
                    n_pos = '0;
                    n_cnt = RW'(i_len);
                end else if (i_stat.keep_overhead) begin
                    n_pos = '0;
                    n_cnt = RW'(i_taps) + RW'(i_len);
                end else begin
                    n_pos = PW'(i_taps >> 1);
                    n_cnt = RW'(i_len);
                end
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_k == '0);
                o_cmd.last  = step_last;
                if (step_last) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + NW'(1);
                end
            end
            S_WAIT: begin
                if (i_stat.done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.final_out = (r_cnt == RW'(1));
                    if (r_cnt == RW'(1)) begin
                        o_cmd.clear_blk = 1'b1;
                        n_state         = S_COLLECT;
                    end else begin
                        n_cnt   = r_cnt - RW'(1);
                        n_pos   = r_pos + PW'(1);
                        n_k     = '0;
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_k     <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

    // Tap index stays inside the taps in use
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_k < i_taps))
        else $error("tap index beyond tap count");

endmodule

// File: test/fir_block_filter_edge_pad_tb.sv
// Self-checking testbench of the block FIR filter with zero or mirror edge padding.
`timescale 1ns / 100ps

module fir_block_filter_edge_pad_tb;
    import firpad_pkg::*;

    localparam int TAP_DEPTH     = 32;
    localparam int BLOCK_DEPTH   = 32;
    localparam int FRAC_BITS     = 15;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_REQS   = 400;
    localparam int CYCLE_LIMIT   = 10000000;
    localparam int PRINT_CAP     = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [FILT_W-1:0] filt;
        logic              fin;
        logic [STAT_W-1:0] stat;
    } t_filt_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  i_s_tlast;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [FILT_W-1:0]     o_m_tdata;
    logic                  o_m_tlast;
    logic [STAT_W-1:0]     o_m_tuser;

    // Predictor state: taps, collected block and register copies
    logic signed [VALUE_W-1:0] coef_mem [TAP_DEPTH];
    logic signed [VALUE_W-1:0] blk_mem [BLOCK_DEPTH];
    int                        blk_len    = 0;
    bit                        blk_ovf    = 1'b0;
    logic                      pad_mirror = 1'b0;
    logic                      full_span  = 1'b0;
    logic [CFG_DATA_W-1:0]     tap_reg    = TAPS_RESET;

    t_filt_result expected_results[$];
    int           error_count = 0;
    int           req_count   = 0;
    int           cycle_count = 0;
    int           hold_left   = 0;
    bit           idle_on     = 1'b1;

    fir_block_filter_edge_pad u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fir_block_filter_edge_pad_tb: done, errors");
            $finish;
        end
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample or tap value with extra weight on the extremes
    function automatic logic [VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        return VALUE_W'($urandom);
    endfunction

    // Tap count register value, out-of-range codes included
    function automatic logic [CFG_DATA_W-1:0] pick_taps();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 6'd0;
            1: return 6'd63;
            2: return CFG_DATA_W'($urandom_range(33, 62));
            3: return 6'd1;
            4: return 6'd32;
            default: return CFG_DATA_W'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic int taps_used();
        if (tap_reg == 0) return 1;
        if (tap_reg > TAP_DEPTH) return TAP_DEPTH;
        return int'(tap_reg);
    endfunction

    // Block extended by zeros or mirrored samples at both ends
    function automatic logic signed [VALUE_W-1:0] padded_sample(int p, int n, int len);
        if (p < n) begin
            if (pad_mirror && (n - 1 - p) < len) return blk_mem[n - 1 - p];
            return '0;
        end
        if (p - n < len) return blk_mem[p - n];
        if (pad_mirror && (p - n - len) < len) return blk_mem[len - 1 - (p - n - len)];
        return '0;
    endfunction

    // One correlation output, rounded half up and saturated
    function automatic logic [FILT_W-1:0] filter_point(int j, int n, int len);
        longint acc;
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += longint'(padded_sample(j + k, n, len)) * longint'(coef_mem[k]);
        acc += longint'(1) << (FRAC_BITS - 1);
        acc = acc >>> FRAC_BITS;
        if (acc > SAT_HI) acc = SAT_HI;
        if (acc < SAT_LO) acc = SAT_LO;
        return acc[FILT_W-1:0];
    endfunction

    // Update the predictor with one accepted request, queue its results
    function automatic void predict_request(logic cmd, logic [CIDX_W-1:0] idx,
                                            logic signed [VALUE_W-1:0] val, logic lst);
        int           n;
        int           len;
        int           start;
        int           cnt;
        bit           pass_thru;
        logic [STAT_W-1:0] st;
        t_filt_result res;
        if (cmd == CMD_COEFF) begin
            coef_mem[idx] = val;
            return;
        end
        if (blk_len < BLOCK_DEPTH) begin
            blk_mem[blk_len] = val;
            blk_len++;
        end else begin
            blk_ovf = 1'b1;
        end
        if (!lst) return;
        n = taps_used();
        len = blk_len;
        st = blk_ovf ? ST_OVERFLOW : ST_FILTERED;
        pass_thru = pad_mirror && (len < n);
        if (pass_thru) begin
            if (!blk_ovf) st = ST_PASS;
            start = 0;
            cnt = len;
        end else if (full_span) begin
            start = 0;
            cnt = n + len;
        end else begin
            start = n / 2;
            cnt = len;
        end
        for (int r = 0; r < cnt; r++) begin
            if (pass_thru) res.filt = {{(FILT_W - VALUE_W){blk_mem[r][VALUE_W-1]}}, blk_mem[r]};
            else res.filt = filter_point(start + r, n, len);
            res.fin = (r == cnt - 1);
            res.stat = st;
            expected_results.push_back(res);
        end
        blk_len = 0;
        blk_ovf = 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        t_filt_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result data %h last %b status %0d",
                                      o_m_tdata, o_m_tlast, o_m_tuser));
            return;
        end
        want = expected_results.pop_front();
        if (o_m_tdata !== want.filt)
            report_mismatch($sformatf("filtered %h, want %h", o_m_tdata, want.filt));
        if (o_m_tlast !== want.fin)
            report_mismatch($sformatf("final flag %b, want %b", o_m_tlast, want.fin));
        if (o_m_tuser !== want.stat)
            report_mismatch($sformatf("status %0d, want %0d", o_m_tuser, want.stat));
    endtask

    // Output side: check accepted results, stall ready at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) check_result();
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
        end
    end

    // Send one request after a random gap and hold it until accepted
    task automatic send_request(input logic cmd, input logic [CIDX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tlast  <= lst;
        i_s_tdata  <= {{(IN_DATA_W - VALUE_W - CIDX_W){1'b0}}, val, idx};
        do @(posedge i_clk); while (!o_s_tready);
        predict_request(cmd, idx, val, lst);
        req_count++;
    endtask

    // Drop valid, wait for all results, then let the block settle
    task automatic drain_and_settle();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers back to back, optionally the unused index too
    task automatic apply_config(input logic [CFG_DATA_W-1:0] edge_d,
                                input logic [CFG_DATA_W-1:0] keep_d,
                                input logic [CFG_DATA_W-1:0] taps_d, input bit spare);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_EDGE_MODE;
        i_cfg_data  <= edge_d;
        @(posedge i_clk);
        i_cfg_index <= CFG_KEEP_OVERHEAD;
        i_cfg_data  <= keep_d;
        @(posedge i_clk);
        i_cfg_index <= CFG_TAP_COUNT;
        i_cfg_data  <= taps_d;
        @(posedge i_clk);
        if (spare) begin
            i_cfg_index <= CFG_SPARE;
            i_cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        pad_mirror = edge_d[0];
        full_span  = keep_d[0];
        tap_reg    = taps_d;
    endtask

    // Block of random samples, coefficient requests sometimes mixed in
    task automatic send_random_block(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_request(CMD_COEFF, CIDX_W'($urandom), rand_value(), 1'($urandom));
            send_request(CMD_SAMPLE, CIDX_W'($urandom), rand_value(), i == len - 1);
        end
    endtask

    // Load every tap once, extremes first; one load carries a stray last flag
    task automatic test_coeff_load();
        for (int i = 0; i < TAP_DEPTH; i++) begin
            if (i == 0) send_request(CMD_COEFF, CIDX_W'(i), 16'h7FFF, 1'b0);
            else if (i == 1) send_request(CMD_COEFF, CIDX_W'(i), 16'h8000, 1'b0);
            else send_request(CMD_COEFF, CIDX_W'(i), rand_value(), i == 5);
        end
    endtask

    // Zero padding, centered outputs, all taps
    task automatic test_zero_padding();
        drain_and_settle();
        apply_config(6'd0, 6'd0, 6'd32, 1'b0);
        send_request(CMD_SAMPLE, 5'd31, 16'h7FFF, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, 16'h8000, 1'b0);
        send_request(CMD_SAMPLE, 5'd21, 16'hFFFF, 1'b0);
        send_request(CMD_SAMPLE, 5'd10, 16'h0001, 1'b1);
    endtask

    // Full output span, coefficient write in the middle of a block
    task automatic test_full_span();
        drain_and_settle();
        apply_config(6'd0, 6'd1, 6'd5, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, 16'd100, 1'b0);
        send_request(CMD_COEFF, 5'd2, 16'd12345, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, -16'sd200, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, 16'd300, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, 16'h8000, 1'b1);
    endtask

    // Mirror mode: short block passes through, longer block is filtered
    task automatic test_mirror();
        drain_and_settle();
        apply_config(6'd1, 6'd0, 6'd8, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, 16'h8000, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, 16'h7FFF, 1'b0);
        send_request(CMD_SAMPLE, 5'd0, 16'hFFFE, 1'b1);
        drain_and_settle();
        apply_config(6'd1, 6'd1, 6'd4, 1'b0);
        send_random_block(6);
    endtask

    // Tap count zero acts as one, above the maximum acts as the maximum
    task automatic test_tap_bounds();
        drain_and_settle();
        apply_config(6'd0, 6'd0, 6'd0, 1'b0);
        send_random_block(2);
        drain_and_settle();
        apply_config(6'd0, 6'd1, 6'd63, 1'b1);
        send_random_block(3);
    endtask

    // Two samples past the buffer, the last one dropped too
    task automatic test_block_overflow();
        drain_and_settle();
        apply_config(6'd1, 6'd0, 6'd32, 1'b0);
        send_random_block(BLOCK_DEPTH + 2);
    endtask

    // Random phases: new settings, then blocks with stray coefficient requests
    task automatic test_random_traffic();
        int stop_at;
        int r;
        int len;
        stop_at = req_count + RANDOM_REQS;
        while (req_count < stop_at) begin
            drain_and_settle();
            idle_on = ($urandom_range(0, 3) != 0);
            apply_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), pick_taps(),
                         $urandom_range(0, 7) == 0);
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_request(CMD_COEFF, CIDX_W'($urandom), rand_value(),
                                     1'($urandom));
                r = $urandom_range(0, 9);
                if (r == 0) len = $urandom_range(BLOCK_DEPTH + 1, BLOCK_DEPTH + 4);
                else if (r == 1) len = 1;
                else len = $urandom_range(1, 12);
                send_random_block(len);
            end
        end
        idle_on = 1'b1;
    endtask

    // Reset, run the tests in turn, report
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_EDGE_MODE;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        i_s_tuser   <= CMD_COEFF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_coeff_load();
        test_zero_padding();
        test_full_span();
        test_mirror();
        test_tap_bounds();
        test_block_overflow();
        test_random_traffic();
        drain_and_settle();
        if (error_count == 0) begin
            $display("fir_block_filter_edge_pad_tb: done, clean");
        end else begin
            $display("fir_block_filter_edge_pad_tb: done, errors");
        end
        $finish;
    end

endmodule
